// ===== src/msc_pkg.sv =====
// Shared types and constants of the masked stream compaction block.
// Holds the item structs, the input kind codes and the register indexes.
// Depends on nothing; the top level and both bench files import it.
package msc_pkg;

    localparam int MSC_MAX_COND   = 4096;
    localparam int MSC_DATA_WIDTH = 64;

    localparam int VALUE_W  = 64;
    localparam int AXIS_W   = 16;
    localparam int INNER_W  = 24;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        logic               keep;
        logic               end_res;
    } t_out_item;

endpackage

// ===== src/msc_cond_store.sv =====
// One-bit-wide condition store with one write port and one registered read port.
// The read register only updates when a read is enabled, so it holds while stalled.
// Depends on nothing.
module msc_cond_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_wr_bit,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic              o_rd_bit
);

    logic r_mem [DEPTH];
    logic r_rd_bit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_bit <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;

endmodule

// ===== src/masked_stream_compaction.sv =====
// Top level of the masked stream compaction block: counters, pipeline and output register.
// Depends on msc_pkg and on msc_cond_store for the condition bits.
//
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item can be accepted in every cycle unless a stalled output holds the read stage.
// The condition-store read is registered at the accepting edge and the output register follows.
// A stalled output holds the item in the read stage, and the input waits only then.
// Reset is synchronous and active low; it clears counters, valid flags and settings, not the store.
// The configuration port is always ready.
module masked_stream_compaction
    import msc_pkg::*;
#(
    parameter int MAX_COND   = MSC_MAX_COND,
    parameter int DATA_WIDTH = MSC_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (MAX_COND > 1) ? $clog2(MAX_COND) : 1;
    localparam int CNT_W  = $clog2(MAX_COND + 1);
    localparam logic [CNT_W-1:0]   MAX_CNT = CNT_W'(MAX_COND);
    localparam logic [INNER_W-1:0] MAX_POS = INNER_W'(MAX_COND);

    logic                  r_axis_mode;
    logic [AXIS_W-1:0]     r_axis_len;
    logic [INNER_W-1:0]    r_inner_len;

    logic [CNT_W-1:0]      r_cond_count, n_cond_count;
    logic [INNER_W-1:0]    r_inner_pos, n_inner_pos;
    logic [AXIS_W-1:0]     r_axis_pos, n_axis_pos;

    logic                  r_s1_valid;
    logic                  r_s1_inrange;
    logic                  r_s1_last;
    logic [DATA_WIDTH-1:0] r_s1_data;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  w_accept;
    logic                  w_is_data;
    logic                  w_is_load;
    logic                  w_is_clear;
    logic [INNER_W-1:0]    w_pos;
    logic                  w_inrange;
    logic                  w_wr_en;
    logic                  w_cond_q;
    logic                  w_s1_keep;
    logic                  w_s1_prod;
    logic                  w_out_free;
    logic                  w_s1_drain;
    logic [INNER_W-1:0]    w_inner_eff;
    logic [AXIS_W-1:0]     w_axis_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_mode <= 1'b0;
            r_axis_len  <= AXIS_W'(1);
            r_inner_len <= INNER_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AXIS_MODE: r_axis_mode <= i_cfg_data[0];
                CFG_AXIS_LEN:  r_axis_len  <= i_cfg_data[AXIS_W-1:0];
                CFG_INNER_LEN: r_inner_len <= i_cfg_data[INNER_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_data  = (i_in_item.kind == KIND_DATA);
    assign w_is_load  = (i_in_item.kind == KIND_LOAD);
    assign w_is_clear = (i_in_item.kind == KIND_CLEAR);

    assign w_pos      = r_axis_mode ? INNER_W'(r_axis_pos) : r_inner_pos;
    assign w_inrange  = (w_pos < INNER_W'(r_cond_count));
    assign w_wr_en    = w_accept && w_is_load && (r_cond_count < MAX_CNT);

    assign w_inner_eff = (r_inner_len == '0) ? INNER_W'(1) : r_inner_len;
    assign w_axis_eff  = (r_axis_len == '0) ? AXIS_W'(1) : r_axis_len;

    always_comb begin
        n_cond_count = r_cond_count;
        n_inner_pos  = r_inner_pos;
        n_axis_pos   = r_axis_pos;
        if (w_accept) begin
            if (w_is_clear) begin
                n_cond_count = '0;
                n_inner_pos  = '0;
                n_axis_pos   = '0;
            end else if (w_is_load) begin
                if (r_cond_count < MAX_CNT) begin
                    n_cond_count = r_cond_count + CNT_W'(1);
                end
            end else if (w_is_data) begin
                if (i_in_item.last) begin
                    n_inner_pos = '0;
                    n_axis_pos  = '0;
                end else if (r_axis_mode) begin
                    if (({1'b0, r_inner_pos} + (INNER_W+1)'(1)) >= {1'b0, w_inner_eff}) begin
                        n_inner_pos = '0;
                        if (({1'b0, r_axis_pos} + (AXIS_W+1)'(1)) >= {1'b0, w_axis_eff}) begin
                            n_axis_pos = '0;
                        end else begin
                            n_axis_pos = r_axis_pos + AXIS_W'(1);
                        end
                    end else begin
                        n_inner_pos = r_inner_pos + INNER_W'(1);
                    end
                end else if (r_inner_pos < MAX_POS) begin
                    n_inner_pos = r_inner_pos + INNER_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond_count <= '0;
            r_inner_pos  <= '0;
            r_axis_pos   <= '0;
        end else begin
            r_cond_count <= n_cond_count;
            r_inner_pos  <= n_inner_pos;
            r_axis_pos   <= n_axis_pos;
        end
    end

    msc_cond_store #(
        .DEPTH (MAX_COND)
    ) u_cond_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_cond_count[ADDR_W-1:0]),
        .i_wr_bit  (|i_in_item.value),
        .i_rd_en   (w_accept && w_is_data),
        .i_rd_addr (w_pos[ADDR_W-1:0]),
        .o_rd_bit  (w_cond_q)
    );

    assign w_s1_keep  = r_s1_inrange && w_cond_q;
    assign w_s1_prod  = r_s1_valid && (w_s1_keep || r_s1_last);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_drain = !w_s1_prod || w_out_free;
    assign o_in_ready = !r_s1_valid || w_s1_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_accept && w_is_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_data) begin
            r_s1_inrange <= w_inrange;
            r_s1_last    <= i_in_item.last;
            r_s1_data    <= i_in_item.value[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_s1_prod) begin
            r_out_item.data    <= w_s1_keep ? VALUE_W'(r_s1_data) : '0;
            r_out_item.keep    <= w_s1_keep;
            r_out_item.end_res <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.keep |-> o_out_item.end_res && (o_out_item.data == '0))
        else $error("result without keep is not a clean end marker");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cond_count <= MAX_CNT)
        else $error("condition count beyond store depth");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_is_clear |=> (r_cond_count == '0) && (r_inner_pos == '0))
        else $error("clear item did not reset the counters");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_drain |=> r_s1_valid && $stable(r_s1_data))
        else $error("stalled item left the read stage");

endmodule

// ===== bench/msc_compaction_checker.sv =====
`timescale 1ns / 1ps
// Checker for the masked stream compaction block: it watches the input, output and
// register channels, predicts the compacted stream and compares it item by item.
// Depends on msc_pkg; tb_top instantiates it beside the block and reads its counts.
module msc_compaction_checker
    import msc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 100;
    localparam logic [VALUE_W-1:0] DATA_MASK = {VALUE_W{1'b1}} >> (VALUE_W - MSC_DATA_WIDTH);

    logic        cond_store [MSC_MAX_COND];
    int unsigned cond_count = 0;
    int unsigned inner_pos = 0;
    int unsigned axis_pos = 0;
    logic        axis_mode = 1'b0;
    int unsigned axis_len = 1;
    int unsigned inner_len = 1;
    t_out_item   selected_q [$];
    int          fail_count = 0;

    function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        end
    endfunction

    function automatic void predict_compaction(input t_in_item it);
        int unsigned pos;
        int unsigned il;
        int unsigned al;
        logic        kept;
        t_out_item   res;
        case (it.kind)
            KIND_CLEAR: begin
                cond_count = 0;
                inner_pos  = 0;
                axis_pos   = 0;
            end
            KIND_LOAD: begin
                if (cond_count < MSC_MAX_COND) begin
                    cond_store[cond_count] = (it.value != '0);
                    cond_count++;
                end
            end
            KIND_DATA: begin
                pos  = axis_mode ? axis_pos : inner_pos;
                kept = (pos < cond_count) && cond_store[pos];
                il   = (inner_len == 0) ? 1 : inner_len;
                al   = (axis_len == 0) ? 1 : axis_len;
                if (it.last) begin
                    inner_pos = 0;
                    axis_pos  = 0;
                end else if (axis_mode) begin
                    if (inner_pos + 1 >= il) begin
                        inner_pos = 0;
                        axis_pos  = (axis_pos + 1 >= al) ? 0 : axis_pos + 1;
                    end else begin
                        inner_pos++;
                    end
                end else if (inner_pos < MSC_MAX_COND) begin
                    inner_pos++;
                end
                if (kept || it.last) begin
                    res.data    = kept ? (it.value & DATA_MASK) : '0;
                    res.keep    = kept;
                    res.end_res = it.last;
                    selected_q.insert(selected_q.size(), res);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cond_count = 0;
            inner_pos  = 0;
            axis_pos   = 0;
            axis_mode  = 1'b0;
            axis_len   = 1;
            inner_len  = 1;
            selected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AXIS_MODE: axis_mode = i_cfg_data[0];
                    CFG_AXIS_LEN:  axis_len  = i_cfg_data[AXIS_W-1:0];
                    CFG_INNER_LEN: inner_len = i_cfg_data[INNER_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_compaction(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (selected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $error("result with none expected: data %0h, keep %0b, end_res %0b",
                               i_out_item.data, i_out_item.keep, i_out_item.end_res);
                    end
                end else begin
                    want = selected_q.pop_front();
                    check_field("data", want.data, i_out_item.data);
                    check_field("keep", VALUE_W'(want.keep), VALUE_W'(i_out_item.keep));
                    check_field("end_res", VALUE_W'(want.end_res), VALUE_W'(i_out_item.end_res));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= selected_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for masked_stream_compaction: clock, reset, stimulus and verdict.
// Depends on msc_pkg, the block itself and msc_compaction_checker.
module tb_top;
    import msc_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 130;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          mismatches;
    int          pending;
    int          stall_cycles = 0;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 78;
    int          items_sent = 0;
    logic        cur_axis_mode = 1'b0;
    int unsigned cur_axis_len = 1;
    int unsigned cur_inner_len = 1;

    masked_stream_compaction dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    msc_compaction_checker compaction_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("masked_stream_compaction: mismatch");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [KIND_W-1:0] kind,
                                           input logic [VALUE_W-1:0] value, input logic last);
        t_in_item it;
        it.kind  = kind;
        it.value = value;
        it.last  = last;
        return it;
    endfunction

    function automatic logic [VALUE_W-1:0] cond_value();
        case ($urandom_range(3))
            0:       return '0;
            1:       return VALUE_W'($urandom_range(1, 255));
            2:       return VALUE_W'(1) << $urandom_range(VALUE_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        if (it.kind != KIND_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic mode, input int unsigned alen,
                                  input int unsigned ilen);
        write_reg(CFG_AXIS_MODE, {23'($urandom), mode});
        write_reg(CFG_AXIS_LEN, {8'($urandom), 16'(alen)});
        write_reg(CFG_INNER_LEN, 24'(ilen));
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_UNUSED, 24'($urandom));
        end
        cur_axis_mode = mode;
        cur_axis_len  = alen & 32'hFFFF;
        cur_inner_len = ilen & 32'hFF_FFFF;
    endtask

    task automatic send_job(input int n_cond, input int n_data, input bit clear_first,
                            input bit end_tensor, input int noise_pct);
        int               i;
        logic [KIND_W-1:0] kind;
        if (clear_first) begin
            send_item(make_item(KIND_CLEAR, {$urandom, $urandom}, 1'($urandom_range(1))));
        end
        for (i = 0; i < n_cond; i++) begin
            send_item(make_item(KIND_LOAD, cond_value(), 1'($urandom_range(1))));
        end
        for (i = 0; i < n_data; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0:       kind = KIND_CLEAR;
                    1:       kind = KIND_LOAD;
                    default: kind = KIND_UNUSED;
                endcase
                send_item(make_item(kind, cond_value(), 1'($urandom_range(1))));
            end
            send_item(make_item(KIND_DATA, {$urandom, $urandom},
                                end_tensor && (i == n_data - 1)));
        end
    endtask

    initial begin
        int          regime;
        int          phase;
        int          target;
        int          n_cond;
        int          n_data;
        int unsigned al;
        int unsigned il;
        longint      span;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(KIND_CLEAR, '0, 1'b0));
        send_item(make_item(KIND_LOAD, 64'h1, 1'b0));
        send_item(make_item(KIND_LOAD, '0, 1'b1));
        send_item(make_item(KIND_LOAD, 64'h8000_0000_0000_0000, 1'b0));
        send_item(make_item(KIND_LOAD, '1, 1'b0));
        send_item(make_item(KIND_LOAD, '0, 1'b0));
        send_item(make_item(KIND_DATA, '1, 1'b0));
        send_item(make_item(KIND_DATA, '0, 1'b0));
        send_item(make_item(KIND_DATA, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0));
        send_item(make_item(KIND_DATA, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0));
        send_item(make_item(KIND_DATA, '1, 1'b0));
        send_item(make_item(KIND_DATA, 64'h0123_4567_89AB_CDEF, 1'b0));
        send_item(make_item(KIND_DATA, 64'hFEDC_BA98_7654_3210, 1'b1));
        send_item(make_item(KIND_DATA, 64'hDEAD_BEEF_0000_0001, 1'b1));
        send_item(make_item(KIND_UNUSED, '1, 1'b1));

        drain();
        apply_settings(1'b1, 3, 2);
        send_job(0, 6, 1'b0, 1'b1, 0);

        // Zero lengths must behave as lengths of one.
        drain();
        apply_settings(1'b1, 0, 0);
        send_job(0, 3, 1'b0, 1'b1, 0);

        // Run a flat tensor well past the end of its conditions.
        drain();
        apply_settings(1'b0, 1, 1);
        send_job(24, 40, 1'b1, 1'b1, 0);

        for (regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (phase = 0; phase < 4; phase++) begin
                drain();
                if (phase == 3) begin
                    apply_settings(1'(regime), 65535, 16777215);
                end else begin
                    case ($urandom_range(9))
                        0:       al = 0;
                        1:       al = 65535;
                        2:       al = 1;
                        default: al = $urandom_range(2, 12);
                    endcase
                    case ($urandom_range(9))
                        0:       il = 0;
                        1:       il = 16777215;
                        2:       il = 1;
                        default: il = $urandom_range(2, 4);
                    endcase
                    apply_settings(1'($urandom_range(1)), al, il);
                end
                target = items_sent + PHASE_ITEMS;
                while (items_sent < target) begin
                    al = (cur_axis_len == 0) ? 1 : cur_axis_len;
                    il = (cur_inner_len == 0) ? 1 : cur_inner_len;
                    if (cur_axis_mode) begin
                        n_cond = $urandom_range(0, (al > 20) ? 20 : al + 2);
                        span   = longint'(al) * longint'(il);
                        if (span <= 48) begin
                            n_data = int'(span) * $urandom_range(1, 2);
                        end else begin
                            n_data = $urandom_range(1, 48);
                        end
                    end else begin
                        n_cond = $urandom_range(0, 32);
                        n_data = $urandom_range(1, 40);
                    end
                    send_job(n_cond, n_data, $urandom_range(9) != 0,
                             $urandom_range(19) != 0, 5);
                end
            end
        end

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("masked_stream_compaction: match");
        end else begin
            $display("masked_stream_compaction: mismatch");
        end
        $finish;
    end

endmodule
